@@ hw/rtl/cbsf_pkg.sv @@
// Shared types and constants of the 3x3 box / Sobel filter.
// Used by every module of the block; no dependencies.
package cbsf_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned HEIGHT_LIMIT  = 4096;
	localparam int unsigned ROW_W         = 13;
	localparam int unsigned SUM_W         = 12;
	localparam int unsigned CNT_W         = 4;
	localparam int unsigned CFG_DATA_W    = 13;

	localparam logic [1:0] MODE_BOX  = 2'd0;
	localparam logic [1:0] MODE_VERT = 2'd1;
	localparam logic [1:0] MODE_HORZ = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} in_item_t;

	typedef struct packed {
		logic [9:0] red_out;
		logic [9:0] green_out;
		logic [9:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
		logic calc;
		logic take;
	} ctl_cmd_t;

	typedef struct packed {
		logic drop;
		logic emit;
		logic box;
		logic div_busy;
	} dp_status_t;

endpackage

@@ hw/rtl/conv3x3_box_sobel_filter.sv @@
// Streaming 3x3 box mean / Sobel filter on RGBA pixels, top level; uses cbsf_ctrl, cbsf_datapath.
// out_valid rises after the input transfer once S_READ (window shift) and S_WIN (compute)
// have passed in Sobel modes, and also S_DIV (the reciprocal multiply) in box mean.
// A new item is taken only in S_IDLE: no new pixel is taken until the last result has
// been taken, unless the last item was dropped or gave no result.
// Reset (arst_n low): counters and window clear, mode box, width min(1024, MAX_WIDTH), height 768.
module conv3x3_box_sobel_filter import cbsf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	cbsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cbsf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/cbsf_div.sv @@
// Reciprocal-multiply divider for the box mean; the neighbour count is 1, 2, 3, 4, 6 or 9.
// Depends on cbsf_pkg.
module cbsf_div import cbsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [9:0]       quotient,
	output logic             busy
);

	localparam int unsigned RCP_SH = 16;
	localparam int unsigned RCP_W  = RCP_SH + 1;
	localparam int unsigned PROD_W = SUM_W + RCP_W;

	logic [SUM_W-1:0]  dvd_q;
	logic [RCP_W-1:0]  rcp_q;
	logic [RCP_W-1:0]  rcp_c;
	logic [PROD_W-1:0] prod;
	logic [9:0]        quo_q;
	logic              busy_q;

	// reciprocals rounded up: exact for every sum up to nine full-scale taps
	always_comb begin
		unique case (divisor)
			CNT_W'(2): rcp_c = RCP_W'(32768);
			CNT_W'(3): rcp_c = RCP_W'(21846);
			CNT_W'(4): rcp_c = RCP_W'(16384);
			CNT_W'(6): rcp_c = RCP_W'(10923);
			CNT_W'(9): rcp_c = RCP_W'(7282);
			default:   rcp_c = RCP_W'(65536);
		endcase
	end

	assign prod = PROD_W'(dvd_q) * PROD_W'(rcp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else
			busy_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rcp_q <= rcp_c;
		end
		if (busy_q)
			quo_q <= prod[RCP_SH +: 10];
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

@@ hw/rtl/cbsf_ctrl.sv @@
// Controller state machine: sequences read, window shift, compute, divide, output.
// Depends on cbsf_pkg.
module cbsf_ctrl import cbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_WIN  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid && !status.drop) state_d = S_READ;
			S_READ: state_d = status.emit ? S_WIN : S_IDLE;
			S_WIN:  state_d = status.box ? S_DIV : S_OUT;
			S_DIV:  if (!status.div_busy) state_d = S_OUT;
			S_OUT:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid && !status.drop;
		cmd.step = (state_q == S_READ);
		cmd.calc = (state_q == S_WIN);
		cmd.take = (state_q == S_OUT) && out_ready;
	end

endmodule

@@ hw/rtl/cbsf_datapath.sv @@
// Datapath: registers, counters, line buffer memory, 3x3 window and filter arithmetic.
// Depends on cbsf_pkg and cbsf_div.
module cbsf_datapath import cbsf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_cmd_t              cmd,
	output dp_status_t            status,
	output out_item_t             out_data
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned FW_W  = COL_W + 1;

	logic [1:0]       mode_q;
	logic [FW_W-1:0]  fw_q;
	logic [ROW_W-1:0] fh_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [ROW_W-2:0] out_row_q;
	logic [31:0]      px_q;
	logic [63:0]      rd_q;
	logic [63:0]      mem_q [MAX_WIDTH];
	logic [31:0]      win_q [9];
	logic [9:0]       abs_q [3];
	logic             box_q, last_q;
	logic [7:0]       alpha_q;

	logic             restart;
	logic             is_box, last_c;
	logic [2:0]       row_ok, col_ok;
	logic [CNT_W-1:0] cnt_c;
	logic [SUM_W-1:0] sum_c [3];
	logic [9:0]       abs_c [3];
	logic [9:0]       quo   [3];
	logic             busy  [3];
	logic [10:0]      wcfg;
	logic [31:0]      wclip;
	logic [12:0]      hcfg;

	// configuration, with clamping
	assign wcfg  = cfg_data[10:0];
	assign hcfg  = cfg_data[12:0];
	assign wclip = (wcfg == '0) ? 32'd1 :
		(32'(wcfg) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(wcfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BOX;
			fw_q   <= FW_W'((1024 > MAX_WIDTH) ? MAX_WIDTH : 1024);
			fh_q   <= ROW_W'(768);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[1:0];
				REG_WIDTH:  fw_q   <= FW_W'(wclip);
				REG_HEIGHT: fh_q   <= (hcfg == '0) ? ROW_W'(1) :
					(32'(hcfg) > HEIGHT_LIMIT) ? ROW_W'(HEIGHT_LIMIT) : hcfg;
				default: ;
			endcase
		end
	end

	assign restart = (cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
		|| (cmd.take && last_q);

	always_comb begin
		if (in_data.opcode == OP_PIXEL)
			status.drop = in_row_q >= fh_q;
		else
			status.drop = in_row_q < fh_q;
		status.emit     = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
		status.box      = is_box;
		status.div_busy = busy[0] || busy[1] || busy[2];
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cmd.step) begin
				if ({1'b0, in_col_q} + FW_W'(1) >= fw_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.take) begin
				if ({1'b0, out_col_q} + FW_W'(1) >= fw_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// line buffers: each word holds {upper row, middle row}
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= mem_q[in_col_q];
			px_q <= (in_data.opcode == OP_DRAIN) ? 32'd0 :
				{in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
		end
		if (cmd.step)
			mem_q[in_col_q] <= {rd_q[31:0], px_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (cmd.step) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= rd_q[63:32];
			win_q[5] <= rd_q[31:0];
			win_q[8] <= px_q;
		end
	end

	// border masks and filter sums
	always_comb begin
		logic [7:0]  t [9];
		logic [10:0] pos, neg;
		logic [11:0] diff;
		row_ok[0] = out_row_q != '0;
		row_ok[1] = 1'b1;
		row_ok[2] = {1'b0, out_row_q} + ROW_W'(1) < fh_q;
		col_ok[0] = out_col_q != '0;
		col_ok[1] = 1'b1;
		col_ok[2] = {1'b0, out_col_q} + FW_W'(1) < fw_q;
		cnt_c  = CNT_W'({2'b00, 2'd1 + row_ok[0] + row_ok[2]} *
			{2'b00, 2'd1 + col_ok[0] + col_ok[2]});
		is_box = !(mode_q == MODE_VERT || mode_q == MODE_HORZ);
		last_c = !row_ok[2] && !col_ok[2];
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++)
				t[i] = (row_ok[i/3] && col_ok[i%3]) ? win_q[i][8*ch +: 8] : 8'd0;
			sum_c[ch] = SUM_W'(t[0]) + t[1] + t[2] + t[3] + t[4] + t[5] + t[6] + t[7] + t[8];
			if (mode_q == MODE_VERT) begin
				pos = 11'(t[2]) + {t[5], 1'b0} + t[8];
				neg = 11'(t[0]) + {t[3], 1'b0} + t[6];
			end else begin
				pos = 11'(t[6]) + {t[7], 1'b0} + t[8];
				neg = 11'(t[0]) + {t[1], 1'b0} + t[2];
			end
			diff = {1'b0, pos} - {1'b0, neg};
			abs_c[ch] = diff[11] ? 10'(-diff) : diff[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			for (int ch = 0; ch < 3; ch++)
				abs_q[ch] <= abs_c[ch];
			box_q   <= is_box;
			last_q  <= last_c;
			alpha_q <= win_q[4][31:24];
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_div
		cbsf_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (cmd.calc && is_box),
			.dividend (sum_c[ch]),
			.divisor  (cnt_c),
			.quotient (quo[ch]),
			.busy     (busy[ch])
		);
	end

	always_comb begin
		out_data.red_out    = box_q ? quo[0] : abs_q[0];
		out_data.green_out  = box_q ? quo[1] : abs_q[1];
		out_data.blue_out   = box_q ? quo[2] : abs_q[2];
		out_data.alpha_out  = alpha_q;
		out_data.frame_last = last_q;
	end

endmodule

@@ bench/conv3x3_box_sobel_filter_check.sv @@
// Checker for the 3x3 box / Sobel filter: watches the pixel, result and register channels,
// predicts each result and compares it with what the block delivers.
// Depends on cbsf_pkg.
module conv3x3_box_sobel_filter_check import cbsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE = MAX_WIDTH_DEF;
	localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
	localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

	logic [31:0] line_mem [0:2*LINE-1];
	logic [31:0] win [0:8];
	int unsigned in_col, in_row, out_col, out_row;
	logic [1:0]  mode;
	int unsigned width, height;
	out_item_t   expected_q [$];

	assign pending = expected_q.size();

	initial begin
		errors = 0;
		for (int i = 0; i < 2*LINE; i++)
			line_mem[i] = '0;
	end

	function automatic void restart_counts();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic void write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int unsigned v;
		case (idx)
			REG_MODE: mode = val[1:0];
			REG_WIDTH: begin
				v = val[10:0];
				width = (v == 0) ? 1 : (v > LINE) ? LINE : v;
				restart_counts();
			end
			REG_HEIGHT: begin
				v = val[12:0];
				height = (v == 0) ? 1 : (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
				restart_counts();
			end
			default: ;
		endcase
	endfunction

	// Advance the window by one item, unless it is dropped, and queue the filtered pixel it completes, if any.
	function automatic void filter_step(input in_item_t it);
		logic [31:0] px, top, mid;
		int unsigned col;
		bit          fire;
		int          acc, cnt, v, kr, kc;
		out_item_t   res;
		if (it.opcode == OP_PIXEL) begin
			if (in_row >= height)
				return;
			px = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
		end else begin
			if (in_row < height)
				return;
			px = '0;
		end
		col = in_col;
		top = line_mem[col];
		mid = line_mem[LINE + col];
		line_mem[col] = mid;
		line_mem[LINE + col] = px;
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3 + 1];
			win[r*3+1] = win[r*3 + 2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		fire = in_row >= 2 || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= width) begin
			in_col = 0;
			in_row++;
		end
		if (!fire)
			return;
		for (int ch = 0; ch < 3; ch++) begin
			acc = 0;
			cnt = 0;
			for (int k = 0; k < 9; k++) begin
				kr = k / 3;
				kc = k % 3;
				if (kr == 0 && out_row == 0) continue;
				if (kr == 2 && out_row + 1 >= height) continue;
				if (kc == 0 && out_col == 0) continue;
				if (kc == 2 && out_col + 1 >= width) continue;
				v = win[k][8*ch +: 8];
				cnt++;
				case (mode)
					MODE_VERT: acc += v * KX[k];
					MODE_HORZ: acc += v * KY[k];
					default:   acc += v;
				endcase
			end
			if (mode == MODE_VERT || mode == MODE_HORZ)
				acc = (acc < 0) ? -acc : acc;
			else
				acc = acc / cnt;
			case (ch)
				0: res.red_out   = acc[9:0];
				1: res.green_out = acc[9:0];
				default: res.blue_out = acc[9:0];
			endcase
		end
		res.alpha_out  = win[4][31:24];
		res.frame_last = (out_row + 1 >= height) && (out_col + 1 >= width);
		expected_q.push_back(res);
		if (res.frame_last) begin
			restart_counts();
		end else begin
			out_col++;
			if (out_col >= width) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	function automatic void compare(input out_item_t got);
		out_item_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
				got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out ||
				got.frame_last !== want.frame_last) begin
			$display("%0t: mismatch expected r%0d g%0d b%0d a%0d last%0d, got r%0d g%0d b%0d a%0d last%0d",
				$time, want.red_out, want.green_out, want.blue_out, want.alpha_out,
				want.frame_last, got.red_out, got.green_out, got.blue_out, got.alpha_out,
				got.frame_last);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			restart_counts();
			mode   = MODE_BOX;
			width  = 1024;
			height = 768;
		end else begin
			if (cfg_valid && cfg_ready)
				write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				filter_step(in_data);
			if (out_valid && out_ready)
				compare(out_data);
		end
	end

endmodule

@@ bench/conv3x3_box_sobel_filter_test.sv @@
// Testbench top of the 3x3 box / Sobel filter: clock, reset, pixel and register stimulus,
// receiver back-pressure, watchdog and verdict. Depends on cbsf_pkg, the block and its checker.
module conv3x3_box_sobel_filter_test;
	import cbsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int SETTLE  = 40;
	localparam int STALL_LIMIT = 3000;
	localparam int ITEM_TARGET = 1750;

	localparam int PAT_RANDOM = 0;
	localparam int PAT_CHECKER = 1;
	localparam int PAT_VSTEP = 2;
	localparam int PAT_HSTEP = 3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors, pending;
	int                    items_sent = 0;
	int                    idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	conv3x3_box_sobel_filter u_dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	conv3x3_box_sobel_filter_check u_check (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
	);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("conv3x3_box_sobel_filter test failed");
			$finish;
		end
	end

	// Receiver: random stalls, stretches without any, and one long hold-off.
	initial begin
		int taken, stall;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 300) begin
				out_ready <= 1'b0;
				repeat (500) @(posedge clk);
			end
			stall = ((taken / 64) % 4 == 2) ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Valid stays high into the next item when there is no gap.
	task automatic send(input in_item_t it);
		int gap;
		gap = ((items_sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_shape(input logic [1:0] md, input int w, input int h);
		wait_idle();
		write_reg(REG_MODE, md);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_pixel(input int pat, input int r, input int c,
			input int w, input int h);
		in_item_t it;
		logic [7:0] v;
		it = {OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
		case (pat)
			PAT_CHECKER: v = ((r + c) % 2) ? 8'hff : 8'h00;
			PAT_VSTEP:   v = (c >= w / 2) ? 8'hff : 8'h00;
			PAT_HSTEP:   v = (r >= h / 2) ? 8'hff : 8'h00;
			default:     return it;
		endcase
		it.red_in   = v;
		it.green_in = ~v;
		it.blue_in  = v;
		it.alpha_in = ~v;
		return it;
	endfunction

	function automatic in_item_t make_drain();
		return {OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
	endfunction

	// One frame in raster order, then the drain ticks that flush it; noise adds ignored
	// drains inside the frame and dropped pixels after its last pixel.
	task automatic frame(input int w, input int h, input int pat, input bit noisy);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				if (noisy && $urandom_range(0, 9) == 0)
					send(make_drain());
				send(make_pixel(pat, r, c, w, h));
			end
		if (noisy && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) send(make_pixel(PAT_RANDOM, 0, 0, w, h));
		repeat (w + 1) send(make_drain());
		if (noisy && $urandom_range(0, 3) == 0)
			send(make_drain());
	endtask

	initial begin
		int w, h;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_shape(MODE_BOX, 3, 3);
		frame(3, 3, PAT_CHECKER, 0);
		set_shape(MODE_VERT, 4, 3);
		frame(4, 3, PAT_VSTEP, 0);
		set_shape(MODE_HORZ, 3, 4);
		frame(3, 4, PAT_HSTEP, 0);
		set_shape(MODE_RSVD, 2, 2);
		frame(2, 2, PAT_RANDOM, 0);
		// out-of-range sizes clamp to one
		set_shape(MODE_VERT, 0, 0);
		frame(1, 1, PAT_RANDOM, 0);
		set_shape(MODE_HORZ, 1, 3);
		frame(1, 3, PAT_CHECKER, 0);
		set_shape(MODE_BOX, 4, 1);
		frame(4, 1, PAT_RANDOM, 1);
		// saturating sizes: feed part of a huge frame, then abort it by rewriting the shape
		set_shape(MODE_BOX, 2047, 8191);
		repeat (20) send(make_pixel(PAT_RANDOM, 0, 0, 1, 1));
		set_shape(MODE_VERT, 3, 2);
		frame(3, 2, PAT_RANDOM, 1);

		// widest row: fill the whole line buffer, then abort early in the second row
		set_shape(MODE_BOX, 1024, 2);
		repeat (1030) send(make_pixel(PAT_RANDOM, 0, 0, 1, 1));

		while (items_sent < ITEM_TARGET) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			set_shape(2'($urandom_range(0, 3)), w, h);
			if ($urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(1, w * h))
					send(make_pixel(PAT_RANDOM, 0, 0, w, h));
			end else begin
				frame(w, h, $urandom_range(0, 3), $urandom_range(0, 2) == 0);
			end
		end

		wait_idle();
		if (errors == 0 && pending == 0)
			$display("conv3x3_box_sobel_filter test passed");
		else
			$display("conv3x3_box_sobel_filter test failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/cbsf_pkg.sv
hw/rtl/cbsf_div.sv
hw/rtl/cbsf_ctrl.sv
hw/rtl/cbsf_datapath.sv
hw/rtl/conv3x3_box_sobel_filter.sv
bench/conv3x3_box_sobel_filter_check.sv
bench/conv3x3_box_sobel_filter_test.sv
